// ----- rtl/apse_pkg.sv -----
package apse_pkg;

    // Low five bits of a NAL header byte hold the NAL type.
    localparam logic [7:0] NAL_TYPE_MASK  = 8'h1F;
    localparam int         NAL_TYPE_W     = 5;
    localparam logic [31:0] MASK_RESET    = 32'h0000_0180;

    localparam logic [7:0] BYTE_ZERO      = 8'h00;
    localparam logic [7:0] BYTE_ONE       = 8'h01;

    // Zero bytes held back while a start code may still be forming.
    localparam logic [1:0] ZERO_RUN_MAX   = 2'd3;
    localparam logic [1:0] ZERO_RUN_CODE  = 2'd2;

    // Number of zeros of the fresh 00 00 00 01 prefix.
    localparam logic [2:0] PREFIX_ZEROS   = 3'd3;

    // One classified input byte: what the back end has to emit for it.
    typedef struct packed {
        logic [7:0] data;       // byte to emit when emit_data is set
        logic [2:0] zeros;      // zero bytes to emit first, 0 to 4
        logic       emit_one;   // emit 01 after the zeros
        logic       emit_data;  // emit data last
        logic       unit_end;   // the byte closed the access unit
        logic       found;      // params_found to report on every result
    } cmd_t;

    // Queue status seen by the input handshake and the back end.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- rtl/apse_front.sv -----
module apse_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               unit_last,
    output logic               push,
    output apse_pkg::cmd_t     cmd
);

    logic [31:0] mask_reg;
    logic [1:0]  zero_run_reg, zero_run_next;
    logic        expect_reg, expect_next;
    logic        copying_reg, copying_next;
    logic        found_reg, found_next;

    logic [apse_pkg::NAL_TYPE_W-1:0] hdr_type;
    logic [2:0] zeros;
    logic       emit_one;
    logic       emit_data;

    assign hdr_type = data_byte[apse_pkg::NAL_TYPE_W-1:0];

    always_comb
    begin
        zero_run_next = zero_run_reg;
        expect_next   = expect_reg;
        copying_next  = copying_reg;
        found_next    = found_reg;
        zeros         = 3'd0;
        emit_one      = 1'b0;
        emit_data     = 1'b0;

        if (expect_reg)
        begin
            // The byte after a start code is always the header.
            expect_next   = 1'b0;
            zero_run_next = 2'd0;
            copying_next  = mask_reg[hdr_type];
            if (mask_reg[hdr_type])
            begin
                found_next = 1'b1;
                zeros      = apse_pkg::PREFIX_ZEROS;
                emit_one   = 1'b1;
                emit_data  = 1'b1;
            end
        end
        else if (data_byte == apse_pkg::BYTE_ZERO)
        begin
            if (zero_run_reg < apse_pkg::ZERO_RUN_MAX)
                zero_run_next = zero_run_reg + 2'd1;
            else if (copying_reg)
                zeros = 3'd1;
        end
        else if (data_byte == apse_pkg::BYTE_ONE && zero_run_reg >= apse_pkg::ZERO_RUN_CODE)
        begin
            zero_run_next = 2'd0;
            copying_next  = 1'b0;
            expect_next   = 1'b1;
        end
        else
        begin
            if (copying_reg)
            begin
                zeros     = {1'b0, zero_run_reg};
                emit_data = 1'b1;
            end
            zero_run_next = 2'd0;
        end

        // Held zeros belong to the current NAL unit when the access unit ends.
        if (unit_last && copying_next)
            zeros = zeros + {1'b0, zero_run_next};

        cmd.data      = data_byte;
        cmd.zeros     = zeros;
        cmd.emit_one  = emit_one;
        cmd.emit_data = emit_data;
        cmd.unit_end  = unit_last;
        cmd.found     = found_next;

        push = accept && (unit_last || emit_one || emit_data || (zeros != 3'd0));

        if (unit_last)
        begin
            zero_run_next = 2'd0;
            expect_next   = 1'b0;
            copying_next  = 1'b0;
            found_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg     <= apse_pkg::MASK_RESET;
            zero_run_reg <= 2'd0;
            expect_reg   <= 1'b0;
            copying_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mask_reg <= cfg_wdata;
            if (accept)
            begin
                zero_run_reg <= zero_run_next;
                expect_reg   <= expect_next;
                copying_reg  <= copying_next;
                found_reg    <= found_next;
            end
        end
    end

endmodule

// ----- rtl/apse_fifo.sv -----
module apse_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  apse_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output apse_pkg::cmd_t      head_cmd,
    output apse_pkg::q_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    apse_pkg::cmd_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign head_cmd     = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ----- rtl/apse_back.sv -----
module apse_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  apse_pkg::cmd_t      head_cmd,
    input  apse_pkg::q_status_t status,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [2:0]          m_tuser
);

    apse_pkg::cmd_t cur_reg, cur_next;
    logic           cur_valid_reg, cur_valid_next;

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_last_reg;
    logic [2:0] out_user_reg;

    logic [2:0] remaining;
    logic       final_res;
    logic       load;
    logic [7:0] res_data;
    logic       res_valid;

    always_comb
    begin
        remaining = cur_reg.zeros + {2'b00, cur_reg.emit_one} + {2'b00, cur_reg.emit_data};
        final_res = (remaining <= 3'd1);
        load      = cur_valid_reg && (!out_valid_reg || m_tready);

        res_valid = 1'b1;
        if (cur_reg.zeros != 3'd0)
            res_data = apse_pkg::BYTE_ZERO;
        else if (cur_reg.emit_one)
            res_data = apse_pkg::BYTE_ONE;
        else if (cur_reg.emit_data)
            res_data = cur_reg.data;
        else
        begin
            res_data  = apse_pkg::BYTE_ZERO;
            res_valid = 1'b0;
        end

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (load)
        begin
            if (cur_reg.zeros != 3'd0)
                cur_next.zeros = cur_reg.zeros - 3'd1;
            else if (cur_reg.emit_one)
                cur_next.emit_one = 1'b0;
            else
                cur_next.emit_data = 1'b0;
            if (final_res)
                cur_valid_next = 1'b0;
        end

        pop = !status.empty && (!cur_valid_reg || (load && final_res));
        if (pop)
        begin
            cur_next       = head_cmd;
            cur_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load)
        begin
            out_data_reg <= res_data;
            out_last_reg <= final_res && cur_reg.unit_end;
            out_user_reg <= {cur_reg.found, final_res, res_valid};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- rtl/annexb_param_set_extractor.sv -----
// Extracts the parameter sets (or any NAL types chosen in wanted_type_mask,
// reset value 0x180 for types 7 and 8) from an Annex B access unit streamed
// one byte per transaction, with tlast on the final byte. Every wanted NAL
// unit leaves with a fresh 00 00 00 01 prefix; bytes before the first start
// code and all unwanted NAL units are dropped. One input transaction gives
// zero to five output transactions: tuser[1] marks the last one belonging to
// an input byte, tlast marks the end of the access unit, and a byte that ends
// the unit without any data gets one bare end marker (tuser[0] low). An input
// byte is accepted in every cycle while the command queue has room; the back
// end then delivers one output transaction per cycle while m_tready is high,
// so a byte holds the output for all of its results (at most five, for a new
// NAL header) and the queue of QUEUE_DEPTH entries absorbs such bursts. Write
// wanted_type_mask through cfg_we/cfg_wdata only while no transaction is in flight.
module annexb_param_set_extractor
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: wanted_type_mask.
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // unit_last
    // Output stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // unit_done
    output logic [2:0]  m_tuser    // [0] byte_valid, [1] run_last, [2] params_found
);

    logic                accept;
    logic                push;
    logic                pop;
    apse_pkg::cmd_t      push_cmd;
    apse_pkg::cmd_t      head_cmd;
    apse_pkg::q_status_t q_status;

    // The front end classifies a byte in the cycle it is accepted, so it only
    // needs one free queue slot to take it.
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    apse_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .data_byte (s_tdata),
        .unit_last (s_tlast),
        .push      (push),
        .cmd       (push_cmd)
    );

    // Commands that produce no output are never queued.
    apse_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    apse_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .status   (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTH
    // The end of an access unit is always the last result of its input byte.
    a_done_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1])
        else $error("unit end not on last result of its byte");

    // A bare end marker carries a zero byte and closes the access unit.
    a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && m_tuser[1] && m_tdata == 8'h00)
        else $error("malformed end marker");

    // The queue is never written while it is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("command queue overflow");

    // The queue is never read while it is empty.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("command queue underflow");
`endif

endmodule
